[sv/mbs_pkg.sv]
// Package for the Maglev backend selector: command and result types,
// operation codes, register indexes and fixed field widths. No dependencies.
package mbs_pkg;

    localparam int KEY_W      = 104;
    localparam int HASH_BITS  = 4;
    localparam int HASH_STEPS = KEY_W / HASH_BITS;
    localparam int SIZE_W     = 9;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [2:0] MODE_PACKET    = 3'd0;
    localparam logic [2:0] MODE_LOAD_ADDR = 3'd1;
    localparam logic [2:0] MODE_LOAD_PERM = 3'd2;
    localparam logic [2:0] MODE_SET_VALID = 3'd3;
    localparam logic [2:0] MODE_REBUILD   = 3'd4;
    localparam logic [2:0] MODE_CLEAR_ALL = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKEND_COUNT = 1'd1;

    localparam logic [SIZE_W-1:0]  TABLE_SIZE_RESET    = 9'd256;
    localparam logic [COUNT_W-1:0] BACKEND_COUNT_RESET = 4'd8;

    typedef enum logic [2:0] {
        OP_PACKET,
        OP_LOAD_ADDR,
        OP_LOAD_PERM,
        OP_SET_VALID,
        OP_REBUILD,
        OP_CLEAR_ALL,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             in_range;
        logic [KEY_W-1:0] key;
        logic [2:0]       backend_number;
        logic [7:0]       position;
        logic [7:0]       value;
        logic [31:0]      backend_ip;
        logic             valid_flag;
    } t_cmd;

    typedef struct packed {
        logic        drop;
        logic [2:0]  chosen_backend;
        logic [31:0] rewritten_dest_address;
        logic [15:0] passed_dest_port;
        logic [7:0]  slot_index;
    } t_result;

endpackage

[sv/mbs_in_if.sv]
// Input channel of the Maglev backend selector: valid, ready and one item.
// Stands alone; no package is needed.
interface mbs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] source_port_number;
    logic [31:0] dest_address;
    logic [15:0] dest_port_number;
    logic [2:0]  backend_number;
    logic [7:0]  permutation_position;
    logic [7:0]  permutation_value;
    logic [31:0] backend_ip_value;
    logic        valid_flag;

    modport source (
        output valid, mode, ip_protocol, source_address, source_port_number,
               dest_address, dest_port_number, backend_number,
               permutation_position, permutation_value, backend_ip_value,
               valid_flag,
        input  ready
    );
    modport sink (
        input  valid, mode, ip_protocol, source_address, source_port_number,
               dest_address, dest_port_number, backend_number,
               permutation_position, permutation_value, backend_ip_value,
               valid_flag,
        output ready
    );
endinterface

[sv/mbs_out_if.sv]
// Result channel of the Maglev backend selector: valid, ready and one result.
// Stands alone; no package is needed.
interface mbs_out_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic [2:0]  chosen_backend;
    logic [31:0] rewritten_dest_address;
    logic [15:0] passed_dest_port;
    logic [7:0]  slot_index;

    modport source (
        output valid, drop, chosen_backend, rewritten_dest_address,
               passed_dest_port, slot_index,
        input  ready
    );
    modport sink (
        input  valid, drop, chosen_backend, rewritten_dest_address,
               passed_dest_port, slot_index,
        output ready
    );
endinterface

[sv/mbs_front.sv]
// Front end: accepts input items, classifies the mode into an operation and
// checks index ranges. Depends on mbs_pkg and mbs_in_if.
module mbs_front
    import mbs_pkg::*;
#(
    parameter int TABLE_SLOTS  = 256,
    parameter int MAX_BACKENDS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbs_in_if.sink     i_in,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready
);

    t_cmd r_cmd;
    t_cmd n_cmd;
    logic r_valid;
    logic bn_ok;
    logic pos_ok;

    assign bn_ok  = 32'(i_in.backend_number) < MAX_BACKENDS;
    assign pos_ok = 32'(i_in.permutation_position) < TABLE_SLOTS;

    always_comb begin
        n_cmd.key = {i_in.ip_protocol, i_in.source_address, i_in.source_port_number,
                     i_in.dest_address, i_in.dest_port_number};
        n_cmd.backend_number = i_in.backend_number;
        n_cmd.position       = i_in.permutation_position;
        n_cmd.value          = i_in.permutation_value;
        n_cmd.backend_ip     = i_in.backend_ip_value;
        n_cmd.valid_flag     = i_in.valid_flag;
        n_cmd.in_range       = bn_ok;
        case (i_in.mode)
            MODE_PACKET:    n_cmd.op = OP_PACKET;
            MODE_LOAD_ADDR: n_cmd.op = OP_LOAD_ADDR;
            MODE_LOAD_PERM: begin
                n_cmd.op       = OP_LOAD_PERM;
                n_cmd.in_range = bn_ok && pos_ok;
            end
            MODE_SET_VALID: n_cmd.op = OP_SET_VALID;
            MODE_REBUILD:   n_cmd.op = OP_REBUILD;
            MODE_CLEAR_ALL: n_cmd.op = OP_CLEAR_ALL;
            default:        n_cmd.op = OP_NOP;
        endcase
    end

    assign i_in.ready  = !r_valid || i_cmd_ready;
    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[sv/mbs_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on mbs_pkg.
module mbs_queue
    import mbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[sv/mbs_back.sv]
// Back end: hashes packets, looks up the table, loads backend state and
// rebuilds the lookup table. Depends on mbs_pkg and mbs_out_if.
module mbs_back
    import mbs_pkg::*;
#(
    parameter int TABLE_SLOTS  = 256,
    parameter int MAX_BACKENDS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  logic [SIZE_W-1:0]  i_table_size,
    input  logic [COUNT_W-1:0] i_backend_count,
    mbs_out_if.source          o_out
);

    localparam int SW     = $clog2(TABLE_SLOTS);
    localparam int BW     = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int BCW    = $clog2(MAX_BACKENDS + 1);
    localparam int MAXSZ  = (TABLE_SLOTS < 511) ? TABLE_SLOTS : 511;
    localparam int FW     = $clog2(MAXSZ + 1);
    localparam int DEPTH  = MAX_BACKENDS * TABLE_SLOTS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = (SW > SIZE_W) ? SW : SIZE_W;
    localparam int CNT_W  = $clog2(HASH_STEPS);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_HASH     = 8'b0000_0010,
        S_LOOK     = 8'b0000_0100,
        S_RESULT   = 8'b0000_1000,
        S_RB_CLEAR = 8'b0001_0000,
        S_RB_PICK  = 8'b0010_0000,
        S_RB_CHECK = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [SIZE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]   n_rem;
    logic [SIZE_W:0]     step;
    logic [CNT_W-1:0]    r_cnt;
    logic [SIZE_W-1:0]   r_size;
    logic [BCW-1:0]      r_count;
    logic [SIZE_W-1:0]   eff_size;
    logic [BCW-1:0]      eff_count;
    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;
    logic                out_free;

    logic [7:0]          r_perm_mem [DEPTH];
    logic [7:0]          r_perm_q;
    logic [BW-1:0]       r_lut_mem [TABLE_SLOTS];
    logic [BW-1:0]       r_lut_q;
    logic [TABLE_SLOTS-1:0]  r_used;
    logic [MAX_BACKENDS-1:0] r_bvalid;
    logic [31:0]         r_baddr [MAX_BACKENDS];
    logic [FW-1:0]       r_ptr [MAX_BACKENDS];
    logic [FW-1:0]       r_filled;
    logic [BCW-1:0]      r_b;
    logic                r_progress;

    logic [BW-1:0]       b_idx;
    logic [FW-1:0]       cur_ptr;
    logic [XW-1:0]       s_ext;
    logic [SW-1:0]       s_idx;
    logic [XW-1:0]       h_ext;
    logic [SW-1:0]       h_idx;
    logic                s_ok;
    logic                claim;
    logic                start;
    logic                perm_we;
    logic [AW-1:0]       perm_waddr;
    logic [AW-1:0]       perm_raddr;
    logic [BW-1:0]       cmd_b;

    always_comb begin
        if (i_table_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (32'(i_table_size) > TABLE_SLOTS) begin
            eff_size = SIZE_W'(TABLE_SLOTS);
        end else begin
            eff_size = i_table_size;
        end
        if (32'(i_backend_count) > MAX_BACKENDS) begin
            eff_count = BCW'(MAX_BACKENDS);
        end else begin
            eff_count = BCW'(i_backend_count);
        end
    end

    always_comb begin
        step  = '0;
        n_rem = r_rem;
        for (int k = 0; k < HASH_BITS; k++) begin
            step = {n_rem, r_key[KEY_W-1-k]};
            if (step >= {1'b0, r_size}) begin
                step = step - {1'b0, r_size};
            end
            n_rem = step[SIZE_W-1:0];
        end
    end

    assign b_idx      = BW'(r_b);
    assign cur_ptr    = r_ptr[b_idx];
    assign s_ext      = XW'(r_perm_q);
    assign s_idx      = s_ext[SW-1:0];
    assign h_ext      = XW'(r_rem);
    assign h_idx      = h_ext[SW-1:0];
    assign s_ok       = SIZE_W'(r_perm_q) < r_size;
    assign claim      = (r_state == S_RB_CHECK) && s_ok && !r_used[s_idx];
    assign start      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop  = start;
    assign cmd_b      = BW'(i_cmd.backend_number);
    assign perm_we    = start && (i_cmd.op == OP_LOAD_PERM) && i_cmd.in_range;
    assign perm_waddr = AW'(int'(i_cmd.backend_number) * TABLE_SLOTS + int'(i_cmd.position));
    assign perm_raddr = AW'(int'(b_idx) * TABLE_SLOTS + int'(cur_ptr));
    assign out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm_mem[perm_waddr] <= i_cmd.value;
        end
        r_perm_q <= r_perm_mem[perm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            r_lut_mem[s_idx] <= b_idx;
        end
        r_lut_q <= r_lut_mem[h_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_bvalid    <= '1;
            r_size      <= SIZE_W'(1);
            r_filled    <= '0;
            r_b         <= '0;
            r_progress  <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_key   <= i_cmd.key;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_res   <= '0;
                        r_size  <= eff_size;
                        r_count <= eff_count;
                        case (i_cmd.op)
                            OP_PACKET: r_state <= S_HASH;
                            OP_LOAD_ADDR: begin
                                if (i_cmd.in_range) begin
                                    r_baddr[cmd_b] <= i_cmd.backend_ip;
                                end
                                r_state <= S_DONE;
                            end
                            OP_SET_VALID: begin
                                if (i_cmd.in_range) begin
                                    r_bvalid[cmd_b] <= i_cmd.valid_flag;
                                end
                                r_state <= S_RB_CLEAR;
                            end
                            OP_REBUILD: r_state <= S_RB_CLEAR;
                            OP_CLEAR_ALL: begin
                                for (int b = 0; b < MAX_BACKENDS; b++) begin
                                    if (BCW'(b) < eff_count) begin
                                        r_bvalid[b] <= 1'b0;
                                    end
                                end
                                r_state <= S_RB_CLEAR;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_HASH: begin
                    r_rem <= n_rem;
                    r_key <= r_key << HASH_BITS;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(HASH_STEPS - 1)) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: r_state <= S_RESULT;
                S_RESULT: begin
                    if (r_used[h_idx]) begin
                        r_res.drop                   <= 1'b0;
                        r_res.chosen_backend         <= 3'(r_lut_q);
                        r_res.rewritten_dest_address <= r_baddr[r_lut_q];
                    end else begin
                        r_res.drop                   <= 1'b1;
                        r_res.chosen_backend         <= '0;
                        r_res.rewritten_dest_address <= r_cmd.key[47:16];
                    end
                    r_res.passed_dest_port <= r_cmd.key[15:0];
                    r_res.slot_index       <= 8'(r_rem);
                    r_state                <= S_DONE;
                end
                S_RB_CLEAR: begin
                    r_used     <= '0;
                    r_filled   <= '0;
                    r_b        <= '0;
                    r_progress <= 1'b0;
                    for (int b = 0; b < MAX_BACKENDS; b++) begin
                        r_ptr[b] <= '0;
                    end
                    r_state <= S_RB_PICK;
                end
                S_RB_PICK: begin
                    if (SIZE_W'(r_filled) >= r_size) begin
                        r_state <= S_DONE;
                    end else if (r_b >= r_count) begin
                        if (!r_progress) begin
                            r_state <= S_DONE;
                        end else begin
                            r_b        <= '0;
                            r_progress <= 1'b0;
                        end
                    end else if (!r_bvalid[b_idx] || SIZE_W'(cur_ptr) >= r_size) begin
                        r_b <= r_b + BCW'(1);
                    end else begin
                        r_state <= S_RB_CHECK;
                    end
                end
                S_RB_CHECK: begin
                    if (claim) begin
                        r_used[s_idx] <= 1'b1;
                        r_filled      <= r_filled + FW'(1);
                        r_progress    <= 1'b1;
                        r_b           <= r_b + BCW'(1);
                    end else begin
                        r_ptr[b_idx] <= cur_ptr + FW'(1);
                    end
                    r_state <= S_RB_PICK;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid                  = r_out_valid;
    assign o_out.drop                   = r_out.drop;
    assign o_out.chosen_backend         = r_out.chosen_backend;
    assign o_out.rewritten_dest_address = r_out.rewritten_dest_address;
    assign o_out.passed_dest_port       = r_out.passed_dest_port;
    assign o_out.slot_index             = r_out.slot_index;

    a_rem_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH) |-> (r_rem < r_size))
        else $error("Hash remainder is not below the table size.");

    a_filled_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RB_PICK || r_state == S_RB_CHECK) |-> (SIZE_W'(r_filled) <= r_size))
        else $error("Rebuild claimed more slots than the table holds.");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out.valid && r_state == S_IDLE))
        else $error("A finished item did not reach the output register.");

endmodule

[sv/maglev_backend_selector_top.sv]
// Top level of the Maglev backend selector: configuration registers and the
// front end, command queue and back end. Depends on mbs_pkg, both interfaces.
//
// The block selects a backend per packet from a lookup table that a rebuild
// fills round-robin from per-backend slot permutations. A packet item has
// its 104-bit 5-tuple reduced modulo the table size four bits per cycle by a
// chain of four compare-and-subtract steps, followed by a registered table
// read. Load items are written in the idle state and go straight to done in
// the back end. Validity, rebuild and clear-all items run a rebuild, which
// passes through the pick and check states for each permutation entry
// examined and holds off later items while it runs. Up to three items wait in
// the front register and the two-entry queue, so the input keeps accepting
// while a result waits on the output.
module maglev_backend_selector_top
    import mbs_pkg::*;
#(
    parameter int TABLE_SLOTS  = 256,
    parameter int MAX_BACKENDS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mbs_in_if.sink                i_in,
    mbs_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SIZE_W-1:0]  r_table_size;
    logic [COUNT_W-1:0] r_backend_count;
    t_cmd               front_cmd;
    logic               front_valid;
    logic               q_ready;
    t_cmd               q_cmd;
    logic               q_valid;
    logic               q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size    <= TABLE_SIZE_RESET;
            r_backend_count <= BACKEND_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TABLE_SIZE:    r_table_size    <= i_cfg_data[SIZE_W-1:0];
                REG_BACKEND_COUNT: r_backend_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    mbs_front #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_ready)
    );

    mbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    mbs_back #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (q_cmd),
        .i_cmd_valid     (q_valid),
        .o_cmd_pop       (q_pop),
        .i_table_size    (r_table_size),
        .i_backend_count (r_backend_count),
        .o_out           (o_out)
    );

endmodule

[tb/mbs_checker.sv]
`timescale 1ns / 1ps
// Checker for the Maglev backend selector: watches both channels and the
// register port, predicts every result and compares it. Depends on mbs_pkg
// and the two channel interfaces.
module mbs_checker
    import mbs_pkg::*;
#(
    parameter int TABLE_SLOTS  = 256,
    parameter int MAX_BACKENDS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mbs_in_if                     i_in,
    mbs_out_if                    i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_outstanding,
    output int                    o_checked
);

    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         perm_slots [MAX_BACKENDS][TABLE_SLOTS];
    logic               slot_used  [TABLE_SLOTS];
    logic [2:0]         slot_owner [TABLE_SLOTS];
    logic [31:0]        backend_ip [MAX_BACKENDS];
    logic               backend_up [MAX_BACKENDS];
    t_result            pending_results [$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    function automatic int active_size();
        if (size_reg == 0) return 1;
        if (size_reg > TABLE_SLOTS) return TABLE_SLOTS;
        return int'(size_reg);
    endfunction

    function automatic int active_count();
        if (count_reg > MAX_BACKENDS) return MAX_BACKENDS;
        return int'(count_reg);
    endfunction

    function automatic void refill_table();
        int size;
        int cnt;
        int filled;
        int ptr [MAX_BACKENDS];
        bit progress;
        size = active_size();
        cnt = active_count();
        filled = 0;
        progress = 1'b1;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_used[s]  = 1'b0;
            slot_owner[s] = '0;
        end
        for (int b = 0; b < MAX_BACKENDS; b++) ptr[b] = 0;
        while (filled < size && progress) begin
            progress = 1'b0;
            for (int b = 0; b < cnt && filled < size; b++) begin
                if (!backend_up[b]) continue;
                while (ptr[b] < size && (perm_slots[b][ptr[b]] >= size
                       || slot_used[perm_slots[b][ptr[b]]]))
                    ptr[b]++;
                if (ptr[b] < size) begin
                    slot_used[perm_slots[b][ptr[b]]]  = 1'b1;
                    slot_owner[perm_slots[b][ptr[b]]] = 3'(b);
                    filled++;
                    progress = 1'b1;
                end
            end
        end
    endfunction

    function automatic logic [7:0] tuple_slot(logic [7:0] proto, logic [31:0] sip,
                                              logic [15:0] sport, logic [31:0] dip,
                                              logic [15:0] dport);
        longint unsigned v;
        longint unsigned m;
        m = longint'(active_size());
        v = {56'd0, proto};
        v = ((v << 32) | {32'd0, sip}) % m;
        v = ((v << 16) | {48'd0, sport}) % m;
        v = ((v << 32) | {32'd0, dip}) % m;
        v = ((v << 16) | {48'd0, dport}) % m;
        return v[7:0];
    endfunction

    function automatic t_result predict_result();
        t_result r;
        logic [7:0] slot;
        r = '0;
        case (i_in.mode)
            MODE_PACKET: begin
                slot = tuple_slot(i_in.ip_protocol, i_in.source_address,
                                  i_in.source_port_number, i_in.dest_address,
                                  i_in.dest_port_number);
                if (slot_used[slot]) begin
                    r.chosen_backend         = slot_owner[slot];
                    r.rewritten_dest_address = backend_ip[slot_owner[slot]];
                end else begin
                    r.drop                   = 1'b1;
                    r.rewritten_dest_address = i_in.dest_address;
                end
                r.passed_dest_port = i_in.dest_port_number;
                r.slot_index       = slot;
            end
            MODE_LOAD_ADDR: backend_ip[i_in.backend_number] = i_in.backend_ip_value;
            MODE_LOAD_PERM: begin
                perm_slots[i_in.backend_number][i_in.permutation_position] =
                    i_in.permutation_value;
            end
            MODE_SET_VALID: begin
                backend_up[i_in.backend_number] = i_in.valid_flag;
                refill_table();
            end
            MODE_REBUILD: refill_table();
            MODE_CLEAR_ALL: begin
                for (int b = 0; b < active_count(); b++) backend_up[b] = 1'b0;
                refill_table();
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("Result %0d: %s is 0x%0h, expected 0x%0h", o_checked, field, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            size_reg  = TABLE_SIZE_RESET;
            count_reg = BACKEND_COUNT_RESET;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                slot_used[s]  = 1'b0;
                slot_owner[s] = '0;
            end
            for (int b = 0; b < MAX_BACKENDS; b++) backend_up[b] = 1'b1;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_TABLE_SIZE) size_reg = i_cfg_data;
                else if (i_cfg_idx == REG_BACKEND_COUNT) count_reg = i_cfg_data[COUNT_W-1:0];
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("transfer with nothing outstanding, valid",
                                    32'd1, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out.drop !== want.drop)
                        report_mismatch("drop", 32'(i_out.drop), 32'(want.drop));
                    if (i_out.chosen_backend !== want.chosen_backend)
                        report_mismatch("chosen_backend", 32'(i_out.chosen_backend),
                                        32'(want.chosen_backend));
                    if (i_out.rewritten_dest_address !== want.rewritten_dest_address)
                        report_mismatch("rewritten_dest_address",
                                        i_out.rewritten_dest_address,
                                        want.rewritten_dest_address);
                    if (i_out.passed_dest_port !== want.passed_dest_port)
                        report_mismatch("passed_dest_port", 32'(i_out.passed_dest_port),
                                        32'(want.passed_dest_port));
                    if (i_out.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 32'(i_out.slot_index),
                                        32'(want.slot_index));
                    o_checked++;
                end
            end
            if (i_in.valid && i_in.ready)
                pending_results.insert(pending_results.size(), predict_result());
        end
        o_outstanding <= pending_results.size();
    end

endmodule

[tb/maglev_backend_selector_top_test.sv]
`timescale 1ns / 1ps
// Testbench top for the Maglev backend selector: clock, reset, stimulus,
// register writes and verdict. Depends on mbs_pkg, both interfaces, mbs_checker.
module maglev_backend_selector_top_test;
    import mbs_pkg::*;

    localparam int TABLE_SLOTS  = 256;
    localparam int MAX_BACKENDS = 8;
    localparam int STALL_LIMIT  = 60000;
    localparam logic [2:0] MODE_SPARE_LOW  = 3'd6;
    localparam logic [2:0] MODE_SPARE_HIGH = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [15:0] source_port_number;
        logic [31:0] dest_address;
        logic [15:0] dest_port_number;
        logic [2:0]  backend_number;
        logic [7:0]  permutation_position;
        logic [7:0]  permutation_value;
        logic [31:0] backend_ip_value;
        logic        valid_flag;
    } t_stim;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    outstanding;
    int                    checked;
    int                    items_sent = 0;
    int                    lookups_sent = 0;
    int                    settings_used = 0;
    int                    quiet_cycles = 0;
    int                    cur_size = 256;
    int                    cur_count = 8;
    int                    stall_left = 0;
    bit                    calm = 1'b0;
    bit                    perm_loaded [MAX_BACKENDS][TABLE_SLOTS];

    mbs_in_if  in_ch ();
    mbs_out_if out_ch ();

    maglev_backend_selector_top #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mbs_checker #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left   <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic t_stim random_stim();
        t_stim        s;
        int           r;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        s = raw[$bits(t_stim)-1:0];
        r = $urandom_range(0, 99);
        if (r < 55) s.mode = MODE_PACKET;
        else if (r < 63) s.mode = MODE_LOAD_ADDR;
        else if (r < 73) s.mode = MODE_LOAD_PERM;
        else if (r < 84) s.mode = MODE_SET_VALID;
        else if (r < 91) s.mode = MODE_REBUILD;
        else if (r < 95) s.mode = MODE_CLEAR_ALL;
        else if (r < 97) s.mode = MODE_SPARE_LOW;
        else s.mode = MODE_SPARE_HIGH;
        if (s.mode == MODE_SET_VALID) s.valid_flag = ($urandom_range(0, 3) != 0);
        return s;
    endfunction

    task automatic transfer(input t_stim s);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid                <= 1'b1;
        in_ch.mode                 <= s.mode;
        in_ch.ip_protocol          <= s.ip_protocol;
        in_ch.source_address       <= s.source_address;
        in_ch.source_port_number   <= s.source_port_number;
        in_ch.dest_address         <= s.dest_address;
        in_ch.dest_port_number     <= s.dest_port_number;
        in_ch.backend_number       <= s.backend_number;
        in_ch.permutation_position <= s.permutation_position;
        in_ch.permutation_value    <= s.permutation_value;
        in_ch.backend_ip_value     <= s.backend_ip_value;
        in_ch.valid_flag           <= s.valid_flag;
        if (s.mode == MODE_LOAD_PERM) perm_loaded[s.backend_number][s.permutation_position] = 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (s.mode == MODE_PACKET) lookups_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_regs(input int size_val, input int count_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TABLE_SIZE;
        i_cfg_data <= CFG_DATA_W'(size_val);
        @(posedge i_clk);
        i_cfg_idx  <= REG_BACKEND_COUNT;
        i_cfg_data <= CFG_DATA_W'(count_val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_size  = (size_val == 0) ? 1 : (size_val > TABLE_SLOTS) ? TABLE_SLOTS : size_val;
        cur_count = (count_val > MAX_BACKENDS) ? MAX_BACKENDS : count_val;
        settings_used++;
    endtask

    task automatic make_stim(input logic [2:0] mode, input int bn, input int pos,
                             input int val);
        t_stim s;
        s = random_stim();
        s.mode                 = mode;
        s.backend_number       = 3'(bn);
        s.permutation_position = 8'(pos);
        s.permutation_value    = 8'(val);
        transfer(s);
    endtask

    // Every permutation entry a rebuild may read under the current setting is
    // written before any random rebuild can happen.
    task automatic preload_permutations();
        int top_val;
        top_val = cur_size + cur_size / 4;
        if (top_val > 255) top_val = 255;
        for (int b = 0; b < cur_count; b++)
            for (int p = 0; p < cur_size; p++)
                if (!perm_loaded[b][p])
                    make_stim(MODE_LOAD_PERM, b, p, $urandom_range(0, top_val));
    endtask

    task automatic run_phase(input int size_val, input int count_val, input int n);
        drain();
        write_regs(size_val, count_val);
        preload_permutations();
        repeat (n) transfer(random_stim());
    endtask

    initial begin
        t_stim s;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_PACKET;
        in_ch.ip_protocol <= '0;
        in_ch.source_address <= '0;
        in_ch.source_port_number <= '0;
        in_ch.dest_address <= '0;
        in_ch.dest_port_number <= '0;
        in_ch.backend_number <= '0;
        in_ch.permutation_position <= '0;
        in_ch.permutation_value <= '0;
        in_ch.backend_ip_value <= '0;
        in_ch.valid_flag <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table after reset: every lookup drops, field extremes included.
        s = '0;
        s.mode = MODE_PACKET;
        transfer(s);
        s = '1;
        s.mode = MODE_PACKET;
        transfer(s);
        make_stim(MODE_PACKET, 0, 0, 0);
        make_stim(MODE_SPARE_LOW, 0, 0, 0);
        make_stim(MODE_SPARE_HIGH, 7, 255, 255);
        for (int b = 0; b < MAX_BACKENDS; b++) begin
            s = random_stim();
            s.mode = MODE_LOAD_ADDR;
            s.backend_number = 3'(b);
            if (b == 0) s.backend_ip_value = '0;
            if (b == MAX_BACKENDS - 1) s.backend_ip_value = '1;
            transfer(s);
        end

        // A zero table size acts as one slot; an out-of-range entry is skipped.
        drain();
        write_regs(0, 1);
        make_stim(MODE_LOAD_PERM, 0, 0, 5);
        make_stim(MODE_REBUILD, 0, 0, 0);
        make_stim(MODE_PACKET, 0, 0, 0);
        make_stim(MODE_LOAD_PERM, 0, 0, 0);
        make_stim(MODE_REBUILD, 0, 0, 0);
        s = '1;
        s.mode = MODE_PACKET;
        transfer(s);
        make_stim(MODE_CLEAR_ALL, 0, 0, 0);
        make_stim(MODE_PACKET, 0, 0, 0);
        s = random_stim();
        s.mode = MODE_SET_VALID;
        s.backend_number = 3'd0;
        s.valid_flag = 1'b1;
        transfer(s);
        make_stim(MODE_PACKET, 0, 0, 0);

        run_phase(16, 8, 120);
        run_phase(0, 3, 50);
        run_phase(511, 1, 60);
        run_phase(5, 15, 60);
        run_phase(200, 0, 40);
        run_phase(37, 8, 60);
        drain();
        calm = 1'b1;
        run_phase(12, 6, 70);
        drain();

        $display("Sent %0d items (%0d lookups) over %0d register settings,",
                 items_sent, lookups_sent, settings_used);
        $display("with sizes from zero to beyond the table and %0d results compared.",
                 checked);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
